// ----- hw/rtl/fcr_pkg.sv -----
package fcr_pkg;

   typedef logic [2:0] phase_type;
   typedef logic [1:0] status_type;
   typedef logic [2:0] csr_index_type;

   localparam phase_type PH_WAIT = 3'd0;
   localparam phase_type PH_CMD  = 3'd1;
   localparam phase_type PH_LEN  = 3'd2;
   localparam phase_type PH_PAY  = 3'd3;
   localparam phase_type PH_CHK  = 3'd4;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_BAD_LEN = 2'd1;
   localparam status_type ST_UNKNOWN = 2'd2;
   localparam status_type ST_BAD_SUM = 2'd3;

   localparam csr_index_type REG_START_BYTE      = 3'd0;
   localparam csr_index_type REG_IDLE_TIMEOUT    = 3'd1;
   localparam csr_index_type REG_CODE_SET_SPEED  = 3'd2;
   localparam csr_index_type REG_CODE_STOP       = 3'd3;
   localparam csr_index_type REG_CODE_PING       = 3'd4;
   localparam csr_index_type REG_CODE_GET_STATUS = 3'd5;
   localparam csr_index_type REG_CODE_ACK        = 3'd6;

   localparam logic [7:0] LEN_SET_SPEED = 8'd4;
   localparam logic [7:0] LEN_ACK       = 8'd2;
   localparam logic [7:0] LEN_EMPTY     = 8'd0;

   localparam logic       OP_BYTE = 1'b0;
   localparam logic       OP_TICK = 1'b1;

   // first matching code decides
   function automatic status_type check_command(
      input logic [7:0] cmd,
      input logic [7:0] len,
      input logic [7:0] code_set_speed,
      input logic [7:0] code_stop,
      input logic [7:0] code_ping,
      input logic [7:0] code_get_status,
      input logic [7:0] code_ack
   );
      status_type st;
      if (cmd == code_set_speed) begin
         st = (len == LEN_SET_SPEED) ? ST_OK : ST_BAD_LEN;
      end else if (cmd == code_stop || cmd == code_ping || cmd == code_get_status) begin
         st = (len == LEN_EMPTY) ? ST_OK : ST_BAD_LEN;
      end else if (cmd == code_ack) begin
         st = (len == LEN_ACK) ? ST_OK : ST_BAD_LEN;
      end else begin
         st = ST_UNKNOWN;
      end
      return st;
   endfunction

endpackage

// ----- hw/rtl/fcr_req_if.sv -----
interface fcr_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

// ----- hw/rtl/fcr_rsp_if.sv -----
interface fcr_rsp_if;
   logic                  valid;
   logic                  ready;
   logic [7:0]            frame_command;
   logic [7:0]            frame_length;
   fcr_pkg::status_type   frame_status;
   logic [7:0]            payload_byte;
   logic                  payload_valid;
   logic                  last_item;

   modport source (output valid, output frame_command, output frame_length,
                   output frame_status, output payload_byte, output payload_valid,
                   output last_item, input ready);
   modport sink (input valid, input frame_command, input frame_length,
                 input frame_status, input payload_byte, input payload_valid,
                 input last_item, output ready);
endinterface

// ----- hw/rtl/fcr_csr_if.sv -----
interface fcr_csr_if;
   logic                     valid;
   logic                     ready;
   fcr_pkg::csr_index_type   index;
   logic [7:0]               data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/framed_command_receiver_core.sv -----
// Timing: after the transfer of the byte that closes the frame, each result item of the
// frame goes through a payload memory read and then an output register load, the load
// waiting while the sink stalls. Input is taken one byte or tick per cycle while parsing
// and held off while a run streams. Reset (synchronous, active high) clears parser state
// and output valid, loads register defaults; the payload buffer is not cleared.
module framed_command_receiver_core #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic       clock,
   input  logic       reset,
   fcr_req_if.sink    req_bus,
   fcr_rsp_if.source  rsp_bus,
   fcr_csr_if.sink    csr_bus
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int IW = $clog2(MAX_PAYLOAD + 1);
   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   localparam logic [1:0] CTL_PARSE = 2'd0;
   localparam logic [1:0] CTL_READ  = 2'd1;
   localparam logic [1:0] CTL_SEND  = 2'd2;

   // configuration
   logic [7:0] start_byte_ff, idle_timeout_ff, code_set_speed_ff, code_stop_ff;
   logic [7:0] code_ping_ff, code_get_status_ff, code_ack_ff;

   // parser state
   fcr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         held_cmd_ff, held_cmd_in;
   logic [7:0]         held_len_ff, held_len_in;
   logic [IW-1:0]      byte_idx_ff, byte_idx_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         idle_ff, idle_in;

   // run state
   logic [1:0]          ctl_ff, ctl_in;
   logic [7:0]          run_cmd_ff, run_cmd_in;
   logic [7:0]          run_len_ff, run_len_in;
   fcr_pkg::status_type run_status_ff, run_status_in;
   logic                run_hdr_ff, run_hdr_in;
   logic [AW-1:0]       run_idx_ff, run_idx_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_cmd_ff, rsp_cmd_in;
   logic [7:0]          rsp_len_ff, rsp_len_in;
   fcr_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_pvalid_ff, rsp_pvalid_in;
   logic                rsp_last_ff, rsp_last_in;

   // payload memory
   logic [7:0] pay_mem [MAX_PAYLOAD];
   logic [7:0] rd_data_ff;
   logic       pay_we;
   logic [AW-1:0] pay_waddr;
   logic [7:0] pay_wdata;

   logic req_xfer, csr_xfer, out_free, run_last;
   logic [7:0] b, idle_inc;

   assign req_bus.ready = (ctl_ff == CTL_PARSE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_xfer      = csr_bus.valid;
   assign b             = req_bus.data_byte;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign run_last      = run_hdr_ff || ((8'(run_idx_ff) + 8'd1) == run_len_ff);
   assign idle_inc      = (idle_ff < idle_timeout_ff) ? idle_ff + 8'd1 : idle_ff;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.frame_command = rsp_cmd_ff;
   assign rsp_bus.frame_length  = rsp_len_ff;
   assign rsp_bus.frame_status  = rsp_status_ff;
   assign rsp_bus.payload_byte  = rsp_byte_ff;
   assign rsp_bus.payload_valid = rsp_pvalid_ff;
   assign rsp_bus.last_item     = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff      <= 8'd170;
         idle_timeout_ff    <= 8'd10;
         code_set_speed_ff  <= 8'd1;
         code_stop_ff       <= 8'd2;
         code_ping_ff       <= 8'd3;
         code_get_status_ff <= 8'd4;
         code_ack_ff        <= 8'd5;
      end else if (csr_xfer) begin
         unique case (csr_bus.index)
            fcr_pkg::REG_START_BYTE:      start_byte_ff      <= csr_bus.data;
            fcr_pkg::REG_IDLE_TIMEOUT:    idle_timeout_ff    <= csr_bus.data;
            fcr_pkg::REG_CODE_SET_SPEED:  code_set_speed_ff  <= csr_bus.data;
            fcr_pkg::REG_CODE_STOP:       code_stop_ff       <= csr_bus.data;
            fcr_pkg::REG_CODE_PING:       code_ping_ff       <= csr_bus.data;
            fcr_pkg::REG_CODE_GET_STATUS: code_get_status_ff <= csr_bus.data;
            fcr_pkg::REG_CODE_ACK:        code_ack_ff        <= csr_bus.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      held_cmd_in   = held_cmd_ff;
      held_len_in   = held_len_ff;
      byte_idx_in   = byte_idx_ff;
      sum_in        = sum_ff;
      idle_in       = idle_ff;
      ctl_in        = ctl_ff;
      run_cmd_in    = run_cmd_ff;
      run_len_in    = run_len_ff;
      run_status_in = run_status_ff;
      run_hdr_in    = run_hdr_ff;
      run_idx_in    = run_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_pvalid_in = rsp_pvalid_ff;
      rsp_last_in   = rsp_last_ff;
      pay_we        = 1'b0;
      pay_waddr     = byte_idx_ff[AW-1:0];
      pay_wdata     = b;

      unique case (ctl_ff)
         CTL_PARSE: begin
            if (req_xfer && req_bus.opcode == fcr_pkg::OP_TICK) begin
               if (phase_ff != fcr_pkg::PH_WAIT) begin
                  idle_in = idle_inc;
                  if (idle_inc >= idle_timeout_ff) begin
                     phase_in    = fcr_pkg::PH_WAIT;
                     held_len_in = 8'd0;
                     byte_idx_in = '0;
                     sum_in      = 8'd0;
                     idle_in     = 8'd0;
                  end
               end
            end else if (req_xfer) begin
               idle_in = 8'd0;
               unique case (phase_ff)
                  fcr_pkg::PH_WAIT: begin
                     if (b == start_byte_ff) begin
                        phase_in = fcr_pkg::PH_CMD;
                     end
                  end
                  fcr_pkg::PH_CMD: begin
                     held_cmd_in = b;
                     sum_in      = b;
                     phase_in    = fcr_pkg::PH_LEN;
                  end
                  fcr_pkg::PH_LEN: begin
                     held_len_in = b;
                     sum_in      = sum_ff + b;
                     if (b > MAX_LEN) begin
                        run_cmd_in    = held_cmd_ff;
                        run_len_in    = b;
                        run_status_in = fcr_pkg::ST_BAD_LEN;
                        run_hdr_in    = 1'b1;
                        run_idx_in    = '0;
                        ctl_in        = CTL_READ;
                        held_len_in   = 8'd0;
                        byte_idx_in   = '0;
                        sum_in        = 8'd0;
                        phase_in      = (b == start_byte_ff) ? fcr_pkg::PH_CMD
                                                             : fcr_pkg::PH_WAIT;
                     end else if (b == 8'd0) begin
                        phase_in = fcr_pkg::PH_CHK;
                     end else begin
                        byte_idx_in = '0;
                        phase_in    = fcr_pkg::PH_PAY;
                     end
                  end
                  fcr_pkg::PH_PAY: begin
                     pay_we      = (byte_idx_ff < IW'(MAX_PAYLOAD));
                     byte_idx_in = byte_idx_ff + 1'b1;
                     sum_in      = sum_ff + b;
                     if (8'(byte_idx_in) >= held_len_ff) begin
                        phase_in = fcr_pkg::PH_CHK;
                     end
                  end
                  fcr_pkg::PH_CHK: begin
                     run_cmd_in  = held_cmd_ff;
                     run_len_in  = held_len_ff;
                     run_hdr_in  = (held_len_ff == 8'd0);
                     run_idx_in  = '0;
                     ctl_in      = CTL_READ;
                     held_len_in = 8'd0;
                     byte_idx_in = '0;
                     sum_in      = 8'd0;
                     if (b == sum_ff) begin
                        run_status_in = fcr_pkg::check_command(held_cmd_ff, held_len_ff,
                           code_set_speed_ff, code_stop_ff, code_ping_ff,
                           code_get_status_ff, code_ack_ff);
                        phase_in      = fcr_pkg::PH_WAIT;
                     end else begin
                        run_status_in = fcr_pkg::ST_BAD_SUM;
                        phase_in      = (b == start_byte_ff) ? fcr_pkg::PH_CMD
                                                             : fcr_pkg::PH_WAIT;
                     end
                  end
                  default: begin
                     phase_in    = fcr_pkg::PH_WAIT;
                     held_len_in = 8'd0;
                     byte_idx_in = '0;
                     sum_in      = 8'd0;
                  end
               endcase
            end
         end
         CTL_READ: begin
            // memory read of run_idx lands in rd_data_ff this edge
            ctl_in = CTL_SEND;
         end
         CTL_SEND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cmd_in    = run_cmd_ff;
               rsp_len_in    = run_len_ff;
               rsp_status_in = run_status_ff;
               rsp_byte_in   = run_hdr_ff ? 8'd0 : rd_data_ff;
               rsp_pvalid_in = !run_hdr_ff;
               rsp_last_in   = run_last;
               run_idx_in    = run_idx_ff + 1'b1;
               ctl_in        = run_last ? CTL_PARSE : CTL_READ;
            end
         end
         default: ctl_in = CTL_PARSE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= fcr_pkg::PH_WAIT;
         held_cmd_ff  <= 8'd0;
         held_len_ff  <= 8'd0;
         byte_idx_ff  <= '0;
         sum_ff       <= 8'd0;
         idle_ff      <= 8'd0;
         ctl_ff       <= CTL_PARSE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         held_cmd_ff  <= held_cmd_in;
         held_len_ff  <= held_len_in;
         byte_idx_ff  <= byte_idx_in;
         sum_ff       <= sum_in;
         idle_ff      <= idle_in;
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_cmd_ff    <= run_cmd_in;
      run_len_ff    <= run_len_in;
      run_status_ff <= run_status_in;
      run_hdr_ff    <= run_hdr_in;
      run_idx_ff    <= run_idx_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_pvalid_ff <= rsp_pvalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[pay_waddr] <= pay_wdata;
      end
      rd_data_ff <= pay_mem[run_idx_ff];
   end

endmodule

// ----- bench/fcr_frame_checker.sv -----
`timescale 1ns / 1ps
module fcr_frame_checker #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic clock,
   input  logic reset,
   fcr_req_if   req_mon,
   fcr_rsp_if   rsp_mon,
   fcr_csr_if   csr_mon,
   output int   mismatch_count,
   output int   items_due
);

   typedef struct packed {
      logic [7:0]          command;
      logic [7:0]          length;
      fcr_pkg::status_type status;
      logic [7:0]          payload;
      logic                payload_valid;
      logic                last;
   } frame_item_type;

   // register copy
   logic [7:0] cfg_start, cfg_timeout, cfg_speed, cfg_stop, cfg_ping, cfg_status, cfg_ack;

   // parser copy
   fcr_pkg::phase_type phase;
   logic [7:0]         cur_cmd, cur_len, cksum, idle_ticks;
   int                 wr_pos;
   logic [7:0]         pay_mem [MAX_PAYLOAD];

   frame_item_type expected_run_items [$];

   function automatic fcr_pkg::status_type command_verdict(input logic [7:0] cmd,
                                                           input logic [7:0] len);
      if (cmd == cfg_speed)
         return (len == fcr_pkg::LEN_SET_SPEED) ? fcr_pkg::ST_OK : fcr_pkg::ST_BAD_LEN;
      if (cmd == cfg_stop || cmd == cfg_ping || cmd == cfg_status)
         return (len == fcr_pkg::LEN_EMPTY) ? fcr_pkg::ST_OK : fcr_pkg::ST_BAD_LEN;
      if (cmd == cfg_ack)
         return (len == fcr_pkg::LEN_ACK) ? fcr_pkg::ST_OK : fcr_pkg::ST_BAD_LEN;
      return fcr_pkg::ST_UNKNOWN;
   endfunction

   function automatic string item_text(input frame_item_type it);
      return $sformatf("cmd=%02h len=%02h status=%0d byte=%02h pv=%b last=%b",
                       it.command, it.length, it.status, it.payload, it.payload_valid,
                       it.last);
   endfunction

   task automatic back_to_wait();
      phase      = fcr_pkg::PH_WAIT;
      cur_len    = '0;
      wr_pos     = 0;
      cksum      = '0;
      idle_ticks = '0;
   endtask

   // header item for empty or overlong payloads, else one item per stored byte
   task automatic queue_run(input fcr_pkg::status_type st);
      frame_item_type it;
      int k;
      it.command = cur_cmd;
      it.length  = cur_len;
      it.status  = st;
      if (cur_len == 0 || cur_len > MAX_PAYLOAD) begin
         it.payload       = '0;
         it.payload_valid = 1'b0;
         it.last          = 1'b1;
         expected_run_items.push_back(it);
      end else begin
         for (k = 0; k < cur_len; k++) begin
            it.payload       = pay_mem[k];
            it.payload_valid = 1'b1;
            it.last          = (k + 1 == cur_len);
            expected_run_items.push_back(it);
         end
      end
   endtask

   task automatic parse_input(input logic op, input logic [7:0] b);
      if (op == fcr_pkg::OP_TICK) begin
         if (phase != fcr_pkg::PH_WAIT) begin
            if (idle_ticks < cfg_timeout) idle_ticks++;
            if (idle_ticks >= cfg_timeout) back_to_wait();
         end
      end else begin
         idle_ticks = '0;
         case (phase)
            fcr_pkg::PH_WAIT: begin
               if (b == cfg_start) begin
                  back_to_wait();
                  phase = fcr_pkg::PH_CMD;
               end
            end
            fcr_pkg::PH_CMD: begin
               cur_cmd = b;
               cksum   = b;
               phase   = fcr_pkg::PH_LEN;
            end
            fcr_pkg::PH_LEN: begin
               cur_len = b;
               cksum   = cksum + b;
               if (b > MAX_PAYLOAD) begin
                  queue_run(fcr_pkg::ST_BAD_LEN);
                  back_to_wait();
                  if (b == cfg_start) phase = fcr_pkg::PH_CMD;
               end else if (b == fcr_pkg::LEN_EMPTY) begin
                  phase = fcr_pkg::PH_CHK;
               end else begin
                  wr_pos = 0;
                  phase  = fcr_pkg::PH_PAY;
               end
            end
            fcr_pkg::PH_PAY: begin
               if (wr_pos < MAX_PAYLOAD) pay_mem[wr_pos] = b;
               wr_pos++;
               cksum = cksum + b;
               if (wr_pos >= cur_len) phase = fcr_pkg::PH_CHK;
            end
            fcr_pkg::PH_CHK: begin
               if (b == cksum) begin
                  queue_run(command_verdict(cur_cmd, cur_len));
                  back_to_wait();
               end else begin
                  queue_run(fcr_pkg::ST_BAD_SUM);
                  back_to_wait();
                  if (b == cfg_start) phase = fcr_pkg::PH_CMD;
               end
            end
            default: back_to_wait();
         endcase
      end
   endtask

   task automatic note_mismatch(input string what, input string detail);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t mismatch: %s %s", $realtime, what, detail);
   endtask

   always @(posedge clock) begin : watch
      frame_item_type seen, want;
      if (reset) begin
         cfg_start   = 8'd170;
         cfg_timeout = 8'd10;
         cfg_speed   = 8'd1;
         cfg_stop    = 8'd2;
         cfg_ping    = 8'd3;
         cfg_status  = 8'd4;
         cfg_ack     = 8'd5;
         cur_cmd     = '0;
         back_to_wait();
         expected_run_items.delete();
         mismatch_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               fcr_pkg::REG_START_BYTE:      cfg_start   = csr_mon.data;
               fcr_pkg::REG_IDLE_TIMEOUT:    cfg_timeout = csr_mon.data;
               fcr_pkg::REG_CODE_SET_SPEED:  cfg_speed   = csr_mon.data;
               fcr_pkg::REG_CODE_STOP:       cfg_stop    = csr_mon.data;
               fcr_pkg::REG_CODE_PING:       cfg_ping    = csr_mon.data;
               fcr_pkg::REG_CODE_GET_STATUS: cfg_status  = csr_mon.data;
               fcr_pkg::REG_CODE_ACK:        cfg_ack     = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) parse_input(req_mon.opcode, req_mon.data_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{command: rsp_mon.frame_command, length: rsp_mon.frame_length,
                     status: rsp_mon.frame_status, payload: rsp_mon.payload_byte,
                     payload_valid: rsp_mon.payload_valid, last: rsp_mon.last_item};
            if (expected_run_items.size() == 0) begin
               note_mismatch("unexpected result", item_text(seen));
            end else begin
               want = expected_run_items.pop_front();
               if (want !== seen)
                  note_mismatch({"exp ", item_text(want)}, {"got ", item_text(seen)});
            end
         end
      end
      items_due = expected_run_items.size();
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

   localparam int MAX_PAYLOAD  = 32;
   localparam int DRAIN_CYCLES = 100;
   localparam int STRETCH_ITEMS = 65;
   localparam fcr_pkg::csr_index_type REG_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   fcr_req_if req_bus ();
   fcr_rsp_if rsp_bus ();
   fcr_csr_if csr_bus ();

   int mismatch_count;
   int items_due;

   framed_command_receiver_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   fcr_frame_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .mismatch_count (mismatch_count),
      .items_due      (items_due)
   );

   bit         idle_on  = 1'b1;
   bit         stall_on = 1'b1;
   int         req_sent = 0;
   int         rsp_hold = 0;
   logic [7:0] cfg_copy [7];
   logic [7:0] frame_fill [$];

   // sink stalls at random bursts while stall_on is set
   assign rsp_bus.ready = (rsp_hold == 0);

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
         rsp_hold <= $urandom_range(1, 4);
      end
   end

   // call at a falling edge; returns at the falling edge after the transfer, valid still high
   task automatic send_req(input logic op, input logic [7:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      req_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input fcr_pkg::csr_index_type idx, input logic [7:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx != REG_UNUSED) cfg_copy[idx] = val;
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [7:0] sof, input logic [7:0] timeout,
                                input logic [7:0] c_speed, input logic [7:0] c_stop,
                                input logic [7:0] c_ping, input logic [7:0] c_status,
                                input logic [7:0] c_ack);
      write_reg(fcr_pkg::REG_START_BYTE, sof);
      write_reg(fcr_pkg::REG_IDLE_TIMEOUT, timeout);
      write_reg(fcr_pkg::REG_CODE_SET_SPEED, c_speed);
      write_reg(fcr_pkg::REG_CODE_STOP, c_stop);
      write_reg(fcr_pkg::REG_CODE_PING, c_ping);
      write_reg(fcr_pkg::REG_CODE_GET_STATUS, c_status);
      write_reg(fcr_pkg::REG_CODE_ACK, c_ack);
      csr_bus.valid <= 1'b0;
   endtask

   // wait out all result runs plus the streaming latency
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (items_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // now and then a few ticks that stay below the idle timeout
   task automatic ticks_within_timeout();
      int top_n;
      if (cfg_copy[fcr_pkg::REG_IDLE_TIMEOUT] >= 2 && $urandom_range(0, 9) == 0) begin
         top_n = (cfg_copy[fcr_pkg::REG_IDLE_TIMEOUT] > 4) ? 3
                                                           : cfg_copy[fcr_pkg::REG_IDLE_TIMEOUT] - 1;
         repeat ($urandom_range(1, top_n)) send_req(fcr_pkg::OP_TICK, 8'($urandom));
      end
   endtask

   task automatic drop_by_timeout();
      int n;
      n = (cfg_copy[fcr_pkg::REG_IDLE_TIMEOUT] == 0) ? 1 : cfg_copy[fcr_pkg::REG_IDLE_TIMEOUT];
      repeat (n) send_req(fcr_pkg::OP_TICK, 8'($urandom));
   endtask

   // payload comes from frame_fill while it holds bytes, else random
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                             input bit bad_sum, input bit open);
      logic [7:0] sum;
      logic [7:0] b;
      int k;
      if (open) send_req(fcr_pkg::OP_BYTE, cfg_copy[fcr_pkg::REG_START_BYTE]);
      send_req(fcr_pkg::OP_BYTE, cmd);
      sum = cmd;
      ticks_within_timeout();
      send_req(fcr_pkg::OP_BYTE, len);
      sum = sum + len;
      if (len <= MAX_PAYLOAD) begin
         for (k = 0; k < len; k++) begin
            b = (frame_fill.size() != 0) ? frame_fill.pop_front() : 8'($urandom);
            send_req(fcr_pkg::OP_BYTE, b);
            sum = sum + b;
            ticks_within_timeout();
         end
         if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
         send_req(fcr_pkg::OP_BYTE, sum);
      end
   endtask

   function automatic logic [7:0] pick_command();
      fcr_pkg::csr_index_type idx;
      if ($urandom_range(0, 4) != 0) begin
         idx = 3'($urandom_range(fcr_pkg::REG_CODE_SET_SPEED, fcr_pkg::REG_CODE_ACK));
         return cfg_copy[idx];
      end
      return 8'($urandom);
   endfunction

   // half the time the length the command wants, mostly short otherwise
   function automatic logic [7:0] pick_length(input logic [7:0] cmd);
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) begin
         if (cmd == cfg_copy[fcr_pkg::REG_CODE_SET_SPEED]) return fcr_pkg::LEN_SET_SPEED;
         if (cmd == cfg_copy[fcr_pkg::REG_CODE_STOP] || cmd == cfg_copy[fcr_pkg::REG_CODE_PING] ||
             cmd == cfg_copy[fcr_pkg::REG_CODE_GET_STATUS]) return fcr_pkg::LEN_EMPTY;
         if (cmd == cfg_copy[fcr_pkg::REG_CODE_ACK]) return fcr_pkg::LEN_ACK;
      end
      if (r < 8) return 8'($urandom_range(0, 8));
      if (r == 8) return 8'(MAX_PAYLOAD);
      return 8'($urandom_range(0, MAX_PAYLOAD));
   endfunction

   task automatic random_traffic(input int n);
      int goal, sel;
      logic [7:0] cmd, len;
      goal = req_sent + n;
      while (req_sent < goal) begin
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            cmd = pick_command();
            send_frame(cmd, pick_length(cmd), $urandom_range(0, 7) == 0, 1'b1);
         end else if (sel < 78) begin
            repeat ($urandom_range(1, 3)) send_req(fcr_pkg::OP_BYTE, 8'($urandom));
         end else if (sel < 86) begin
            repeat ($urandom_range(1, 4)) send_req(fcr_pkg::OP_TICK, 8'($urandom));
         end else if (sel < 94) begin
            // frame cut short, then dropped by ticks when the timeout is short
            send_req(fcr_pkg::OP_BYTE, cfg_copy[fcr_pkg::REG_START_BYTE]);
            send_req(fcr_pkg::OP_BYTE, pick_command());
            if ($urandom_range(0, 1) == 1) begin
               len = 8'($urandom_range(1, 8));
               send_req(fcr_pkg::OP_BYTE, len);
               repeat ($urandom_range(0, len - 1)) send_req(fcr_pkg::OP_BYTE, 8'($urandom));
            end
            if (cfg_copy[fcr_pkg::REG_IDLE_TIMEOUT] <= 16) drop_by_timeout();
         end else begin
            send_frame(pick_command(), 8'($urandom_range(MAX_PAYLOAD + 1, 255)), 1'b0, 1'b1);
         end
      end
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.opcode    = fcr_pkg::OP_BYTE;
      req_bus.data_byte = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = fcr_pkg::REG_START_BYTE;
      csr_bus.data      = '0;
      // register reset values
      cfg_copy = '{8'd170, 8'd10, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: good frames, overlong length that reopens, bad sum that reopens
      send_frame(cfg_copy[fcr_pkg::REG_CODE_PING], fcr_pkg::LEN_EMPTY, 1'b0, 1'b1);
      frame_fill = '{8'h00, 8'hFF, 8'h80, 8'h7F};
      send_frame(cfg_copy[fcr_pkg::REG_CODE_SET_SPEED], fcr_pkg::LEN_SET_SPEED, 1'b0, 1'b1);
      send_req(fcr_pkg::OP_BYTE, cfg_copy[fcr_pkg::REG_START_BYTE]);
      send_req(fcr_pkg::OP_BYTE, cfg_copy[fcr_pkg::REG_CODE_STOP]);
      send_req(fcr_pkg::OP_BYTE, cfg_copy[fcr_pkg::REG_START_BYTE]);
      send_frame(cfg_copy[fcr_pkg::REG_CODE_ACK], fcr_pkg::LEN_ACK, 1'b0, 1'b0);
      send_req(fcr_pkg::OP_BYTE, cfg_copy[fcr_pkg::REG_START_BYTE]);
      send_req(fcr_pkg::OP_BYTE, cfg_copy[fcr_pkg::REG_CODE_STOP]);
      send_req(fcr_pkg::OP_BYTE, fcr_pkg::LEN_EMPTY);
      send_req(fcr_pkg::OP_BYTE, cfg_copy[fcr_pkg::REG_START_BYTE]);
      send_frame(cfg_copy[fcr_pkg::REG_CODE_STOP], fcr_pkg::LEN_EMPTY, 1'b0, 1'b0);
      random_traffic(STRETCH_ITEMS);
      drain_results();

      // low extremes; ack shares the set_speed code so set_speed wins
      load_settings(8'h00, 8'd1, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'hFF);
      send_req(fcr_pkg::OP_BYTE, cfg_copy[fcr_pkg::REG_START_BYTE]);
      send_req(fcr_pkg::OP_BYTE, cfg_copy[fcr_pkg::REG_CODE_ACK]);
      send_req(fcr_pkg::OP_BYTE, 8'd3);
      send_req(fcr_pkg::OP_TICK, 8'($urandom));
      send_frame(cfg_copy[fcr_pkg::REG_CODE_SET_SPEED], fcr_pkg::LEN_SET_SPEED, 1'b0, 1'b1);
      random_traffic(STRETCH_ITEMS);
      drain_results();

      // high extremes, plus a write to an index that holds no register
      write_reg(REG_UNUSED, 8'($urandom));
      load_settings(8'hFF, 8'd255, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
      random_traffic(STRETCH_ITEMS);
      drain_results();

      // zero timeout drops on the first tick; stop and ack share a code, stop wins
      load_settings(8'h10, 8'd0, 8'h10, 8'h33, 8'($urandom), 8'($urandom), 8'h33);
      send_req(fcr_pkg::OP_BYTE, cfg_copy[fcr_pkg::REG_START_BYTE]);
      send_req(fcr_pkg::OP_BYTE, pick_command());
      send_req(fcr_pkg::OP_TICK, 8'($urandom));
      send_frame(cfg_copy[fcr_pkg::REG_CODE_STOP], fcr_pkg::LEN_EMPTY, 1'b0, 1'b1);
      random_traffic(STRETCH_ITEMS);
      drain_results();

      load_settings(8'($urandom), 8'($urandom_range(1, 20)), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
      random_traffic(STRETCH_ITEMS);
      drain_results();

      // last stretch runs without gaps or stalls
      load_settings(8'($urandom), 8'($urandom_range(2, 8)), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
      idle_on  = 1'b0;
      stall_on = 1'b0;
      random_traffic(STRETCH_ITEMS);
      drain_results();

      if (mismatch_count == 0 && items_due == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
